// ----- src/categorical_table_sampler_assert.svh -----
// ----------------------------------------------------------------------------
// categorical_table_sampler_assert.svh
// Assertion macros shared by the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef CATEGORICAL_TABLE_SAMPLER_ASSERT_SVH
`define CATEGORICAL_TABLE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- src/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the categorical table sampler.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int PROB_W  = 18;
   localparam int DRAW_W  = 16;
   localparam int OUT_IDX_W = 6;
   localparam int IN_IDX_W  = 6;
   localparam int COUNT_W = 7;
   localparam int TOL_W   = 8;
   // Up to 127 entries of 18 bits each can be summed without overflow.
   localparam int SUM_W   = PROB_W + COUNT_W;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_TOLERANCE = 4'd1;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET   = 7'd1;
   localparam logic [TOL_W-1:0]   SUM_TOLERANCE_RESET = 8'd0;

   localparam logic signed [SUM_W-1:0]  ONE_Q16  = 25'sd65536;
   localparam logic signed [PROB_W-1:0] PROB_MIN = 18'sh20000;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct packed {
      logic init;
      logic step;
   } walk_ctl_type;

   typedef struct packed {
      logic found;
      logic neg;
   } walk_flags_type;

endpackage

// ----- src/cts_ram.sv -----
// ----------------------------------------------------------------------------
// cts_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cts_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/cts_walk_unit.sv -----
// ----------------------------------------------------------------------------
// cts_walk_unit
// Shared accumulate-and-compare unit; folds in one table entry per step.
// ----------------------------------------------------------------------------
module cts_walk_unit
   import cts_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic                     clock,
   input  walk_ctl_type             ctl,
   input  logic [IDX_W-1:0]         step_index,
   input  logic signed [PROB_W-1:0] prob,
   input  logic [DRAW_W-1:0]        draw,
   output logic signed [SUM_W-1:0]  sum,
   output logic [IDX_W-1:0]         sample_idx,
   output logic [IDX_W-1:0]         best_idx,
   output logic [IDX_W-1:0]         first_pos_idx,
   output walk_flags_type           flags
);

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [PROB_W-1:0] best_p_ff, best_p_in;
   logic [IDX_W-1:0]         sample_ff, sample_in;
   logic [IDX_W-1:0]         best_ff, best_in;
   logic [IDX_W-1:0]         fpos_ff, fpos_in;
   logic                     found_ff, found_in;
   logic                     fp_found_ff, fp_found_in;
   logic                     neg_ff, neg_in;
   logic signed [SUM_W-1:0]  sum_next;
   logic signed [SUM_W-1:0]  draw_ext;

   assign sum_next = sum_ff + {{(SUM_W-PROB_W){prob[PROB_W-1]}}, prob};
   assign draw_ext = $signed({{(SUM_W-DRAW_W){1'b0}}, draw});

   always_comb begin
      sum_in      = sum_ff;
      best_p_in   = best_p_ff;
      sample_in   = sample_ff;
      best_in     = best_ff;
      fpos_in     = fpos_ff;
      found_in    = found_ff;
      fp_found_in = fp_found_ff;
      neg_in      = neg_ff;
      if (ctl.init) begin
         sum_in      = '0;
         best_p_in   = PROB_MIN;
         sample_in   = '0;
         best_in     = '0;
         fpos_in     = '0;
         found_in    = 1'b0;
         fp_found_in = 1'b0;
         neg_in      = 1'b0;
      end else if (ctl.step) begin
         sum_in = sum_next;
         if (!found_ff && (draw_ext < sum_next)) begin
            sample_in = step_index;
            found_in  = 1'b1;
         end
         // Strict compare keeps the earliest index on ties.
         if (prob > best_p_ff) begin
            best_p_in = prob;
            best_in   = step_index;
         end
         if (!fp_found_ff && (prob > 0)) begin
            fpos_in     = step_index;
            fp_found_in = 1'b1;
         end
         if (prob[PROB_W-1]) begin
            neg_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      best_p_ff   <= best_p_in;
      sample_ff   <= sample_in;
      best_ff     <= best_in;
      fpos_ff     <= fpos_in;
      found_ff    <= found_in;
      fp_found_ff <= fp_found_in;
      neg_ff      <= neg_in;
   end

   assign sum           = sum_ff;
   assign sample_idx    = sample_ff;
   assign best_idx      = best_ff;
   assign first_pos_idx = fpos_ff;
   assign flags.found   = found_ff;
   assign flags.neg     = neg_ff;

endmodule

// ----- src/categorical_table_sampler.sv -----
// ----------------------------------------------------------------------------
// categorical_table_sampler
// Inverse-transform sampler over a table of Q1.16 categorical probabilities.
// ----------------------------------------------------------------------------
// How to use this block:
// The request channel (req_valid / req_stall) carries one word per item.
// A word with req_mode low loads req_probability into entry req_entry_index
// and produces no response; it does not raise req_stall.
// A word with req_mode high brings req_uniform_draw and produces exactly one
// response word on the rsp_ channel carrying the sampled index, the most
// likely index, the first positive index and a table validity flag.
// A sample walks the N entries in use, where N is the entry count capped at
// the table size, then passes a drain state and the finish state, which
// writes the response (with N zero it goes straight to finish); the next
// word can be taken as the response is written. The single table read port
// and the shared accumulate and compare unit fold in one entry per cycle.
// While a sample is being walked, req_stall stays high. A finished response
// sits in the output register, so loads and a new sample are accepted while
// rsp_stall holds the previous response; a sample that finishes while the
// register is still full waits in its last step until the word is taken.
// The csr_ port is a plain write port and may be written only while idle.
// Synchronous reset returns the sequencer to idle, empties the output register
// and restores entry_count to 1 and sum_tolerance to 0. The table itself is
// not cleared; every entry in use must be loaded before it is sampled.
// ----------------------------------------------------------------------------
`include "categorical_table_sampler_assert.svh"

module categorical_table_sampler
   import cts_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [IN_IDX_W-1:0]      req_entry_index,
   input  logic signed [PROB_W-1:0] req_probability,
   input  logic [DRAW_W-1:0]        req_uniform_draw,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_IDX_W-1:0]     rsp_sample_index,
   output logic [OUT_IDX_W-1:0]     rsp_most_likely_index,
   output logic [OUT_IDX_W-1:0]     rsp_first_positive_index,
   output logic                     rsp_table_valid,
   // configuration port
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Configuration registers.
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [TOL_W-1:0]   sum_tol_ff, sum_tol_in;

   // Sequencer state.
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic             pend_ff, pend_in;
   logic [DRAW_W-1:0] draw_ff, draw_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [OUT_IDX_W-1:0] rsp_best_ff, rsp_best_in;
   logic [OUT_IDX_W-1:0] rsp_fpos_ff, rsp_fpos_in;
   logic                 rsp_tv_ff, rsp_tv_in;

   logic             req_accept;
   logic             load_accept;
   logic             sample_accept;
   logic             load_in_range;
   logic [CNT_W-1:0] n_used;
   logic             n_zero;
   logic             last_read;
   logic             slot_free;
   logic             finish_go;

   logic [PROB_W-1:0]        ram_rd_data;
   logic                     ram_rd_en;
   walk_ctl_type             walk_ctl;
   walk_flags_type           walk_flags;
   logic signed [SUM_W-1:0]  walk_sum;
   logic [IDX_W-1:0]         walk_sample;
   logic [IDX_W-1:0]         walk_best;
   logic [IDX_W-1:0]         walk_fpos;
   logic signed [SUM_W-1:0]  sum_dist;
   logic signed [SUM_W-1:0]  tol_ext;
   logic                     sum_ok;

   // A count above the table size saturates to the table size.
   always_comb begin
      if (32'(entry_count_ff) > MAX_ENTRIES) begin
         n_used = CNT_W'(MAX_ENTRIES);
      end else begin
         n_used = CNT_W'(entry_count_ff);
      end
   end

   assign n_zero        = (n_used == '0);
   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign load_in_range = (32'(req_entry_index) < MAX_ENTRIES);
   assign load_accept   = req_accept && (req_mode == MODE_LOAD) && load_in_range;
   assign sample_accept = req_accept && (req_mode == MODE_SAMPLE);
   assign last_read     = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == n_used);
   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign finish_go     = (state_ff == ST_FINISH) && slot_free;
   assign ram_rd_en     = (state_ff == ST_WALK);

   // Configuration writes; writes to unknown indexes are dropped.
   always_comb begin
      entry_count_in = entry_count_ff;
      sum_tol_in     = sum_tol_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENTRY_COUNT: begin
               entry_count_in = csr_write_data[COUNT_W-1:0];
            end
            CSR_SUM_TOLERANCE: begin
               sum_tol_in = csr_write_data[TOL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: one table read is issued per cycle in the walk state, and the
   // entry it returns is folded in by the walk unit on the following cycle.
   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      proc_idx_in = proc_idx_ff;
      pend_in     = 1'b0;
      draw_in     = draw_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_accept) begin
               draw_in   = req_uniform_draw;
               rd_idx_in = '0;
               state_in  = n_zero ? ST_FINISH : ST_WALK;
            end
         end
         ST_WALK: begin
            pend_in     = 1'b1;
            proc_idx_in = rd_idx_ff;
            if (last_read) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign walk_ctl.init = sample_accept;
   assign walk_ctl.step = pend_ff;

   // Distance of the final sum from one, checked against the tolerance.
   assign sum_dist = walk_sum - ONE_Q16;
   assign tol_ext  = $signed({{(SUM_W-TOL_W){1'b0}}, sum_tol_ff});
   assign sum_ok   = (sum_dist <= tol_ext) && (sum_dist >= -tol_ext);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_tv_in     = rsp_tv_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         if (n_zero) begin
            // An empty table reports all zeros and an invalid table.
            rsp_sample_in = '0;
            rsp_best_in   = '0;
            rsp_fpos_in   = '0;
            rsp_tv_in     = 1'b0;
         end else begin
            if (walk_flags.found) begin
               rsp_sample_in = OUT_IDX_W'(walk_sample);
            end else begin
               rsp_sample_in = OUT_IDX_W'(n_used - CNT_W'(1));
            end
            rsp_best_in = OUT_IDX_W'(walk_best);
            rsp_fpos_in = OUT_IDX_W'(walk_fpos);
            rsp_tv_in   = !walk_flags.neg && sum_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
         sum_tol_ff     <= SUM_TOLERANCE_RESET;
         state_ff       <= ST_IDLE;
         rd_idx_ff      <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         sum_tol_ff     <= sum_tol_in;
         state_ff       <= state_in;
         rd_idx_ff      <= rd_idx_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff   <= proc_idx_in;
      draw_ff       <= draw_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_tv_ff     <= rsp_tv_in;
   end

   cts_ram #(
      .WIDTH (PROB_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data (req_probability),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   cts_walk_unit #(
      .IDX_W (IDX_W)
   ) u_walk (
      .clock         (clock),
      .ctl           (walk_ctl),
      .step_index    (proc_idx_ff),
      .prob          ($signed(ram_rd_data)),
      .draw          (draw_ff),
      .sum           (walk_sum),
      .sample_idx    (walk_sample),
      .best_idx      (walk_best),
      .first_pos_idx (walk_fpos),
      .flags         (walk_flags)
   );

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_sample_index         = rsp_sample_ff;
   assign rsp_most_likely_index    = rsp_best_ff;
   assign rsp_first_positive_index = rsp_fpos_ff;
   assign rsp_table_valid          = rsp_tv_ff;

   // A folded-in entry only ever arrives while the table is being walked.
   `CTS_ASSERT_NOW(a_step_in_walk, clock, reset, pend_ff,
      (state_ff == ST_WALK) || (state_ff == ST_DRAIN))
   // The read pointer never runs past the entries in use.
   `CTS_ASSERT_NOW(a_rd_in_range, clock, reset, state_ff == ST_WALK,
      CNT_W'(rd_idx_ff) < n_used)
   // An accepted sample always leaves the idle state.
   `CTS_ASSERT_NEXT(a_sample_busy, clock, reset, sample_accept,
      state_ff != ST_IDLE)
   // Finishing a sample fills the output register and frees the request side.
   `CTS_ASSERT_NEXT(a_finish_out, clock, reset, finish_go,
      rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
